### hw/rtl/fscl_pkg.sv
// Shared types, codes and constants of the SPI configuration loader.
package fscl_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// register indexes on the configuration port
	localparam logic [1:0] REG_DUMMY_CLOCKS = 2'd0;
	localparam logic [1:0] REG_DONE_TRIES   = 2'd1;
	localparam logic [1:0] REG_POWER_HOLD   = 2'd2;
	localparam logic [1:0] REG_RESET_HOLD   = 2'd3;

	localparam logic [5:0]  DUMMY_CLOCKS_RST = 6'd50;
	localparam logic [3:0]  DONE_TRIES_RST   = 4'd3;
	localparam logic [15:0] POWER_HOLD_RST   = 16'd60000;
	localparam logic [9:0]  RESET_HOLD_RST   = 10'd30;

	localparam logic [15:0] HOLD_FINISH_US     = 16'd50;
	localparam logic [15:0] HOLD_RETRY_US      = 16'd20000;
	localparam logic [15:0] HOLD_RESET_HIGH_US = 16'd20000;
	localparam logic [15:0] HOLD_POWER_OFF_US  = 16'd30000;
	localparam logic [15:0] HOLD_RELEASE_US    = 16'd1000;

	localparam logic [3:0] TRIES_MAX = 4'd15;

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_BYTE   = 2'd1,
		REQ_FINISH = 2'd2,
		REQ_DONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LOAD = 3'd1,
		PH_WAIT = 3'd2,
		PH_DONE = 3'd3,
		PH_FAIL = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY   = 3'd0,
		ST_AWAIT  = 3'd1,
		ST_OK     = 3'd2,
		ST_FAILED = 3'd3,
		ST_SEQERR = 3'd4
	} status_t;

	// work handed from the front to the back
	typedef enum logic [2:0] {
		K_START  = 3'd0,
		K_BYTE   = 3'd1,
		K_FINISH = 3'd2,
		K_OK     = 3'd3,
		K_RETRY  = 3'd4,
		K_FAIL   = 3'd5,
		K_SEQERR = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic data;
		logic pwr;
		logic rst;
		logic sel;
	} pins_t;

	typedef struct packed {
		logic        clock_pulse;
		pins_t       pins;
		logic [15:0] hold_us;
		status_t     status;
		logic        last;
	} result_t;

endpackage

### hw/rtl/fscl_front.sv
// Front end: accept request beats, track the load phase and classify each request.
module fscl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 done_level,
	input  logic [3:0]           done_tries,
	input  logic                 q_full,
	output logic                 q_push,
	output fscl_pkg::cmd_t       q_cmd
);
	import fscl_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] tries_q, tries_d;
	logic [3:0] tries_inc;
	logic [3:0] limit;
	logic       accept;

	assign req_ready = !q_full;
	assign accept    = req_valid && req_ready;
	assign q_push    = accept;

	assign tries_inc = (tries_q < TRIES_MAX) ? tries_q + 4'd1 : tries_q;
	assign limit     = (done_tries == 4'd0) ? 4'd1 : done_tries;

	// classify against the current phase
	always_comb begin
		q_cmd.kind = K_SEQERR;
		q_cmd.data = data_byte;
		case (req_t'(req_type))
			REQ_START: begin
				if (phase_q == PH_IDLE || phase_q == PH_DONE || phase_q == PH_FAIL) begin
					q_cmd.kind = K_START;
				end
			end
			REQ_BYTE: begin
				if (phase_q == PH_LOAD) begin
					q_cmd.kind = K_BYTE;
				end
			end
			REQ_FINISH: begin
				if (phase_q == PH_LOAD) begin
					q_cmd.kind = K_FINISH;
				end
			end
			REQ_DONE: begin
				if (phase_q == PH_WAIT) begin
					if (done_level) begin
						q_cmd.kind = K_OK;
					end else if (tries_inc >= limit) begin
						q_cmd.kind = K_FAIL;
					end else begin
						q_cmd.kind = K_RETRY;
					end
				end
			end
			default: begin
				q_cmd.kind = K_SEQERR;
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		tries_d = tries_q;
		if (accept) begin
			case (q_cmd.kind)
				K_START:  phase_d = PH_LOAD;
				K_FINISH: begin
					phase_d = PH_WAIT;
					tries_d = 4'd0;
				end
				K_OK:     phase_d = PH_DONE;
				K_RETRY:  tries_d = tries_inc;
				K_FAIL: begin
					phase_d = PH_FAIL;
					tries_d = tries_inc;
				end
				default:  phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tries_q <= 4'd0;
		end else begin
			phase_q <= phase_d;
			tries_q <= tries_d;
		end
	end

	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && q_cmd.kind == K_START) |=> phase_q == PH_LOAD)
		else $error("start beat did not enter load phase");

endmodule

### hw/rtl/fscl_queue.sv
// Short command queue between the front end and the pin sequencer.
module fscl_queue #(
	parameter int unsigned Depth = fscl_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fscl_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output fscl_pkg::cmd_t head
);
	import fscl_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cmd_t            slot_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

### hw/rtl/fscl_back.sv
// Back end: turn queued commands into pin-level result beats, one per cycle unless stalled.
module fscl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  fscl_pkg::cmd_t       q_cmd,
	output logic                 q_pop,
	input  logic [5:0]           dummy_clocks,
	input  logic [15:0]          power_on_hold_us,
	input  logic [9:0]           reset_low_hold_us,
	output logic                 res_valid,
	input  logic                 res_ready,
	output fscl_pkg::result_t    res
);
	import fscl_pkg::*;

	pins_t      pins_q, pins_d;
	logic [5:0] step_q;
	logic       res_valid_q;
	result_t    res_q, res_d;
	logic       advance;

	assign advance   = q_valid && (!res_valid_q || res_ready);
	assign q_pop     = advance && res_d.last;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		pins_d            = pins_q;
		res_d.clock_pulse = 1'b0;
		res_d.hold_us     = 16'd0;
		res_d.status      = ST_BUSY;
		res_d.last        = 1'b1;
		case (q_cmd.kind)
			K_START: begin
				res_d.last = (step_q[1:0] == 2'd3);
				case (step_q[1:0])
					2'd0: begin
						pins_d        = '{data: 1'b0, pwr: 1'b1, rst: 1'b1, sel: 1'b1};
						res_d.hold_us = power_on_hold_us;
					end
					2'd1: begin
						pins_d.rst    = 1'b1;
						res_d.hold_us = HOLD_RESET_HIGH_US;
					end
					2'd2: begin
						pins_d.sel    = 1'b0;
						pins_d.rst    = 1'b0;
						res_d.hold_us = {6'd0, reset_low_hold_us};
					end
					default: begin
						pins_d.rst    = 1'b1;
						res_d.hold_us = HOLD_RELEASE_US;
					end
				endcase
			end
			K_BYTE: begin
				// msb first: bit 7 - step
				pins_d.data       = q_cmd.data[~step_q[2:0]];
				res_d.clock_pulse = 1'b1;
				res_d.last        = (step_q[2:0] == 3'd7);
			end
			K_FINISH: begin
				if (step_q < dummy_clocks) begin
					res_d.clock_pulse = 1'b1;
					res_d.last        = 1'b0;
				end else begin
					res_d.hold_us = HOLD_FINISH_US;
					res_d.status  = ST_AWAIT;
				end
			end
			K_OK: begin
				res_d.status = ST_OK;
			end
			K_RETRY: begin
				res_d.hold_us = HOLD_RETRY_US;
				res_d.status  = ST_AWAIT;
			end
			K_FAIL: begin
				pins_d.pwr    = 1'b0;
				res_d.hold_us = HOLD_POWER_OFF_US;
				res_d.status  = ST_FAILED;
			end
			default: begin
				res_d.status = ST_SEQERR;
			end
		endcase
		res_d.pins = pins_d;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q      <= '0;
			step_q      <= 6'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pins_q      <= pins_d;
				step_q      <= res_d.last ? 6'd0 : step_q + 6'd1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_pulse_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.clock_pulse) |-> (res_q.hold_us == 16'd0 && !res_q.last
			|| res_q.hold_us == 16'd0 && res_q.status == ST_BUSY))
		else $error("clock pulse beat carries a hold time");

	a_fail_powers_off: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_FAILED) |-> !res_q.pins.pwr)
		else $error("failure beat left power enabled");

endmodule

### hw/rtl/fpga_spi_config_loader.sv
// Top level of the SPI slave configuration loader: register port and front/queue/back.
//
// Loads an SRAM FPGA through a bit-banged SPI slave port. Each request beat
// (start, bitstream byte, finish, done-pin sample) produces one or more result
// beats, each giving the pin levels to apply, whether to pulse the clock, and
// a hold time in microseconds; the last beat of a request is flagged. The back
// sequencer emits one result beat per cycle while the result channel is not stalled;
// a bitstream byte gives 8 beats, a start 4, a finish dummy_clocks + 1, any other 1.
// The front end classifies a request in the cycle it arrives and parks it in
// a small queue (QueueDepth entries), so the next request beat is taken while
// the back end is still shifting out the previous one, and a result beat held
// by a stalled consumer does not stop intake until the queue fills. Requests
// that do not fit the current phase yield a single sequence-error beat and
// leave the state alone. Registers on the APB port (byte addresses):
// 0x0 dummy_clocks, 0x4 done_tries, 0x8 power_on_hold_us, 0xC
// reset_low_hold_us; write them only while no request is in flight.
module fpga_spi_config_loader #(
	parameter int unsigned QueueDepth = fscl_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fscl_pkg::ADDR_W-1:0] paddr,
	input  logic [fscl_pkg::DATA_W-1:0] pwdata,
	output logic [fscl_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  req_type,
	input  logic [7:0]                  data_byte,
	input  logic                        done_level,
	// result channel
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        clock_pulse,
	output logic                        data_out,
	output logic                        power_enable,
	output logic                        cfg_rst,
	output logic                        select_n,
	output logic [15:0]                 hold_us,
	output logic [2:0]                  status,
	output logic                        last
);
	import fscl_pkg::*;

	logic [5:0]  dummy_clocks_q;
	logic [3:0]  done_tries_q;
	logic [15:0] power_hold_q;
	logic [9:0]  reset_hold_q;
	logic        cfg_write;

	cmd_t    push_cmd, head;
	logic    push, pop, full, not_empty;
	result_t res;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// register file: write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dummy_clocks_q <= DUMMY_CLOCKS_RST;
			done_tries_q   <= DONE_TRIES_RST;
			power_hold_q   <= POWER_HOLD_RST;
			reset_hold_q   <= RESET_HOLD_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_DUMMY_CLOCKS: dummy_clocks_q <= pwdata[5:0];
				REG_DONE_TRIES:   done_tries_q   <= pwdata[3:0];
				REG_POWER_HOLD:   power_hold_q   <= pwdata[15:0];
				REG_RESET_HOLD:   reset_hold_q   <= pwdata[9:0];
				default:          dummy_clocks_q <= dummy_clocks_q;
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		case (paddr[3:2])
			REG_DUMMY_CLOCKS: prdata = {26'd0, dummy_clocks_q};
			REG_DONE_TRIES:   prdata = {28'd0, done_tries_q};
			REG_POWER_HOLD:   prdata = {16'd0, power_hold_q};
			REG_RESET_HOLD:   prdata = {22'd0, reset_hold_q};
			default:          prdata = '0;
		endcase
	end

	// classify and hand off
	fscl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.done_level (done_level),
		.done_tries (done_tries_q),
		.q_full     (full),
		.q_push     (push),
		.q_cmd      (push_cmd)
	);

	// decouple intake from pin sequencing
	fscl_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// sequence pins, one result beat per cycle while the result channel is not stalled
	fscl_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (not_empty),
		.q_cmd             (head),
		.q_pop             (pop),
		.dummy_clocks      (dummy_clocks_q),
		.power_on_hold_us  (power_hold_q),
		.reset_low_hold_us (reset_hold_q),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.res               (res)
	);

	assign clock_pulse  = res.clock_pulse;
	assign data_out     = res.pins.data;
	assign power_enable = res.pins.pwr;
	assign cfg_rst      = res.pins.rst;
	assign select_n     = res.pins.sel;
	assign hold_us      = res.hold_us;
	assign status       = res.status;
	assign last         = res.last;

endmodule
